FILE: rtl/core/lat_pkg.sv
// ----------------------------------------------------------------------------
// Latency tracker package
// Shared widths, codes, register defaults and the sequencer's control program.
// ----------------------------------------------------------------------------
`default_nettype none

package lat_pkg;

   // Table size and field widths.
   localparam int CHANNELS = 16;
   localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W    = $clog2(CHANNELS + 1);
   localparam int CHAN_W   = 4;
   localparam int LATIN_W  = 24;
   localparam int LAT_W    = 23;
   localparam int TIME_W   = 48;
   localparam int ENTRY_W  = LAT_W + TIME_W;
   localparam int TGT_W    = 25;
   localparam int MASK_W   = 16;
   localparam int BAND_W   = 16;
   localparam int STALE_W  = 16;
   localparam int MARGIN_W = 12;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   // Hysteresis fraction of the band (seven tenths) by reciprocal multiply.
   localparam int BAND_NUM    = 7;
   localparam int BAND_DEN    = 10;
   localparam int RECIP_SHIFT = 22;
   localparam int RECIP_K     = ((1 << RECIP_SHIFT) + BAND_DEN - 1) / BAND_DEN;
   localparam int BAND7_W     = BAND_W + 3;
   localparam int PROD_W      = 2 * BAND7_W;

   // The target falls by one eighth of the gap.
   localparam int FALL_SHIFT = 3;

   // Register defaults.
   localparam logic                ENABLE_RST = 1'b1;
   localparam logic [BAND_W-1:0]   BAND_RST   = 16'd150;
   localparam logic [STALE_W-1:0]  STALE_RST  = 16'd4000;
   localparam logic [MARGIN_W-1:0] MARGIN_RST = 12'd40;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE = 2'd0,
      CSR_BAND   = 2'd1,
      CSR_STALE  = 2'd2,
      CSR_MARGIN = 2'd3
   } csr_index_type;

   // Item functions.
   typedef enum logic {
      FUNC_REPORT = 1'b0,
      FUNC_UNREG  = 1'b1
   } func_type;

   // Sequencer steps.
   typedef enum logic [2:0] {
      ST_WAIT = 3'd0,
      ST_UPD  = 3'd1,
      ST_MIN  = 3'd2,
      ST_OUT  = 3'd3,
      ST_TGT  = 3'd4,
      ST_SHOW = 3'd5
   } step_type;

   // Jump conditions.
   typedef enum logic [2:0] {
      J_NEXT   = 3'd0,
      J_WAIT   = 3'd1,
      J_SKIP   = 3'd2,
      J_LOOP   = 3'd3,
      J_HOLD   = 3'd4,
      J_ALWAYS = 3'd5
   } jump_type;

   // Evaluation done on the entry read back from the table.
   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_MIN  = 2'd1,
      EV_OUT  = 2'd2
   } eval_type;

   // One control word of the program.
   typedef struct packed {
      logic     ready;
      logic     upd;
      logic     scan;
      eval_type ev;
      logic     tgt;
      logic     show;
      jump_type jump;
      step_type jaddr;
   } ctrl_word_type;

   // Control program: wait, update table, minimum pass, outlier pass,
   // target step, result step.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      w       = '0;
      w.ev    = EV_NONE;
      w.jump  = J_NEXT;
      w.jaddr = ST_WAIT;
      case (step)
         ST_WAIT: begin
            w.ready = 1'b1;
            w.jump  = J_WAIT;
            w.jaddr = ST_WAIT;
         end
         ST_UPD: begin
            w.upd   = 1'b1;
            w.jump  = J_SKIP;
            w.jaddr = ST_SHOW;
         end
         ST_MIN: begin
            w.scan  = 1'b1;
            w.ev    = EV_MIN;
            w.jump  = J_LOOP;
            w.jaddr = ST_MIN;
         end
         ST_OUT: begin
            w.scan  = 1'b1;
            w.ev    = EV_OUT;
            w.jump  = J_LOOP;
            w.jaddr = ST_OUT;
         end
         ST_TGT: begin
            w.tgt   = 1'b1;
         end
         ST_SHOW: begin
            w.show  = 1'b1;
            w.jump  = J_HOLD;
            w.jaddr = ST_SHOW;
         end
         default: begin
            w.jump  = J_ALWAYS;
            w.jaddr = ST_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lat_if.sv
// ----------------------------------------------------------------------------
// Latency tracker channels
// Request channel (latency reports and unregisters) and result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lat_req_if
   import lat_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [CHAN_W-1:0]          channel;
   logic signed [LATIN_W-1:0]  latency;
   logic [TIME_W-1:0]          now_ms;

   modport source (output valid, func, channel, latency, now_ms, input ready);
   modport sink   (input valid, func, channel, latency, now_ms, output ready);
endinterface

interface lat_rsp_if
   import lat_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [TGT_W-1:0]  target;
   logic [MASK_W-1:0]        outlier_mask;

   modport source (output valid, target, outlier_mask, input ready);
   modport sink   (input valid, target, outlier_mask, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lat_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                           clock,
   input  wire logic                                           wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]                               wr_data,
   input  wire logic                                           rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/latency_alignment_target_tracker.sv
// ----------------------------------------------------------------------------
// Latency alignment target tracker
// Per-channel latency table with outlier marking and a smoothed target.
// ----------------------------------------------------------------------------
// Each item occupies the sequencer for one accept step, one table update, two
// passes over the entry memory (one read port with a registered read, so each
// pass walks the channels one per cycle), one target step and one result step.
// A report that is ignored because the block is disabled goes through accept,
// update and result only. The result sits in an output register, so the next
// item is accepted while a result still waits to be taken; if that result is
// still waiting when the next one is ready, the result step holds until it is
// taken. Entry presence lives in flip-flops cleared by reset, so there is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module latency_alignment_target_tracker
   import lat_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   lat_req_if.sink                    req_ch,
   lat_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_W-1:0]      csr_wdata
);

   // Configuration registers.
   logic                 enable_ff;
   logic [BAND_W-1:0]    band_ff;
   logic [STALE_W-1:0]   stale_ff;
   logic [MARGIN_W-1:0]  margin_ff;
   logic [BAND_W-1:0]    band_lo_ff;
   logic [BAND_W-1:0]    band_lo_in;
   logic [BAND7_W-1:0]   band7;
   logic [PROD_W-1:0]    band_prod;

   // Sequencer.
   step_type             upc_ff;
   step_type             upc_in;
   ctrl_word_type        ctrl;
   logic                 taken;
   logic [CNT_W-1:0]     cnt_ff;
   logic [CNT_W-1:0]     cnt_in;
   logic                 rd_en;
   logic                 rd_v_ff;
   logic [ADDR_W-1:0]    rd_idx_ff;

   // Captured item.
   func_type             item_func_ff;
   logic [CHAN_W-1:0]    item_chan_ff;
   logic [LAT_W-1:0]     item_lat_ff;
   logic [TIME_W-1:0]    item_now_ff;
   logic                 accept;
   logic                 chan_ok;
   logic                 skip;
   logic [ADDR_W-1:0]    chan_idx;

   // Table state and working registers.
   logic [CHANNELS-1:0]  present_ff;
   logic [CHANNELS-1:0]  present_in;
   logic [CHANNELS-1:0]  flags_ff;
   logic [CHANNELS-1:0]  flags_in;
   logic [LAT_W-1:0]     best_ff;
   logic [LAT_W-1:0]     best_in;
   logic                 best_v_ff;
   logic                 best_v_in;
   logic [LAT_W-1:0]     worst_ff;
   logic [LAT_W-1:0]     worst_in;
   logic signed [TGT_W-1:0] target_ff;
   logic signed [TGT_W-1:0] target_in;

   // Read-back evaluation.
   logic [ENTRY_W-1:0]   ram_rdata;
   logic [LAT_W-1:0]     rd_lat;
   logic [TIME_W-1:0]    rd_time;
   logic [TIME_W:0]      age;
   logic                 rd_live;
   logic [BAND_W-1:0]    band_use;
   logic [LAT_W:0]       limit;
   logic                 is_outlier;
   logic [LAT_W:0]       wanted;
   logic [LAT_W:0]       gap;

   // Result register.
   logic                 rsp_valid_ff;
   logic signed [TGT_W-1:0] rsp_target_ff;
   logic [MASK_W-1:0]    rsp_mask_ff;
   logic [MASK_W-1:0]    mask_w;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= ENABLE_RST;
         band_ff   <= BAND_RST;
         stale_ff  <= STALE_RST;
         margin_ff <= MARGIN_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE: enable_ff <= csr_wdata[0];
            CSR_BAND:   band_ff   <= csr_wdata[BAND_W-1:0];
            CSR_STALE:  stale_ff  <= csr_wdata[STALE_W-1:0];
            CSR_MARGIN: margin_ff <= csr_wdata[MARGIN_W-1:0];
            default: ;
         endcase
      end
   end

   // Seven tenths of the band, kept in a register; the user must see that the band only
   // changes while the block is idle, as the block itself does not enforce it.
   always_comb begin
      band7      = ({3'b0, band_ff} << 3) - {3'b0, band_ff};
      band_prod  = PROD_W'(band7) * PROD_W'(RECIP_K);
      band_lo_in = band_prod[RECIP_SHIFT +: BAND_W];
   end

   always_ff @(posedge clock) begin
      band_lo_ff <= band_lo_in;
   end

   // Control word fetch and jump decision.
   assign ctrl    = ucode_rom(upc_ff);
   assign accept  = req_ch.valid && req_ch.ready;
   assign chan_ok = int'(item_chan_ff) < CHANNELS;
   assign skip    = !chan_ok || (item_func_ff == FUNC_REPORT && !enable_ff);
   assign chan_idx = ADDR_W'(item_chan_ff);

   always_comb begin
      case (ctrl.jump)
         J_NEXT:   taken = 1'b0;
         J_WAIT:   taken = !accept;
         J_SKIP:   taken = skip;
         J_LOOP:   taken = cnt_ff != CNT_W'(CHANNELS);
         J_HOLD:   taken = rsp_valid_ff && !rsp_ch.ready;
         J_ALWAYS: taken = 1'b1;
         default:  taken = 1'b1;
      endcase
      if (taken) begin
         upc_in = ctrl.jaddr;
      end else if (upc_ff == ST_SHOW) begin
         upc_in = ST_WAIT;
      end else begin
         upc_in = step_type'(upc_ff + 3'd1);
      end
      rd_en  = ctrl.scan && taken;
      cnt_in = rd_en ? cnt_ff + CNT_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= ST_WAIT;
         cnt_ff  <= '0;
         rd_v_ff <= 1'b0;
      end else begin
         upc_ff  <= upc_in;
         cnt_ff  <= cnt_in;
         rd_v_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_idx_ff <= cnt_ff[ADDR_W-1:0];
      end
   end

   assign req_ch.ready = ctrl.ready;

   // Item capture; negative latency is clamped to zero here.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_func_ff <= func_type'(req_ch.func);
         item_chan_ff <= req_ch.channel;
         item_lat_ff  <= req_ch.latency[LATIN_W-1] ? '0 : req_ch.latency[LAT_W-1:0];
         item_now_ff  <= req_ch.now_ms;
      end
   end

   // Entry table: latency and report time per channel.
   lat_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ctrl.upd && !skip && item_func_ff == FUNC_REPORT),
      .wr_addr (chan_idx),
      .wr_data ({item_lat_ff, item_now_ff}),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // Liveness and outlier test of the entry read in the previous cycle.
   // A report newer than the current time counts as live.
   always_comb begin
      rd_lat     = ram_rdata[ENTRY_W-1 -: LAT_W];
      rd_time    = ram_rdata[TIME_W-1:0];
      age        = {1'b0, item_now_ff} - {1'b0, rd_time};
      rd_live    = present_ff[rd_idx_ff] &&
                   (age[TIME_W] || (age[TIME_W-1:0] <= TIME_W'(stale_ff)));
      band_use   = flags_ff[rd_idx_ff] ? band_lo_ff : band_ff;
      limit      = {1'b0, best_ff} + (LAT_W+1)'(band_use);
      is_outlier = {1'b0, rd_lat} > limit;
      wanted     = {1'b0, worst_ff} + (LAT_W+1)'(margin_ff);
      gap        = target_ff[LAT_W:0] - wanted;
   end

   // Table, mark and target updates.
   always_comb begin
      present_in = present_ff;
      flags_in   = flags_ff;
      best_in    = best_ff;
      best_v_in  = best_v_ff;
      worst_in   = worst_ff;
      target_in  = target_ff;

      // Apply the item to the table and start a fresh scan.
      if (ctrl.upd && !skip) begin
         best_v_in = 1'b0;
         worst_in  = '0;
         if (item_func_ff == FUNC_REPORT) begin
            present_in[chan_idx] = 1'b1;
         end else begin
            present_in[chan_idx] = 1'b0;
            flags_in[chan_idx]   = 1'b0;
         end
      end

      // Fastest live channel.
      if (rd_v_ff && ctrl.ev == EV_MIN && rd_live) begin
         if (!best_v_ff || rd_lat < best_ff) begin
            best_in = rd_lat;
         end
         best_v_in = 1'b1;
      end

      // Outlier marks with hysteresis, and the worst inlier.
      if (rd_v_ff && ctrl.ev == EV_OUT && rd_live && best_v_ff) begin
         if (is_outlier) begin
            flags_in[rd_idx_ff] = 1'b1;
         end else begin
            flags_in[rd_idx_ff] = 1'b0;
            if (rd_lat > worst_ff) begin
               worst_in = rd_lat;
            end
         end
      end

      // Target goes to minus one with no live channel, rises at once and falls by an eighth of the gap.
      if (ctrl.tgt) begin
         if (!best_v_ff) begin
            target_in = '1;
         end else if (target_ff[TGT_W-1] || wanted > target_ff[LAT_W:0]) begin
            target_in = TGT_W'(wanted);
         end else begin
            target_in = TGT_W'(target_ff[LAT_W:0] - (gap >> FALL_SHIFT));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         flags_ff   <= '0;
         best_v_ff  <= 1'b0;
         target_ff  <= '1;
      end else begin
         present_ff <= present_in;
         flags_ff   <= flags_in;
         best_v_ff  <= best_v_in;
         target_ff  <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff  <= best_in;
      worst_ff <= worst_in;
   end

   // Outlier mask shows channels 0 to 15.
   for (genvar i = 0; i < MASK_W; i++) begin : g_mask
      if (i < CHANNELS) begin : g_used
         assign mask_w[i] = flags_ff[i];
      end else begin : g_unused
         assign mask_w[i] = 1'b0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.show && !taken) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.show && !taken) begin
         rsp_target_ff <= target_ff;
         rsp_mask_ff   <= mask_w;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.target       = rsp_target_ff;
   assign rsp_ch.outlier_mask = rsp_mask_ff;

`ifndef ASSERT_OFF
   // An accepted item always goes to the table update step.
   a_accept_to_upd: assert property (@(posedge clock) disable iff (reset)
      accept |=> upc_ff == ST_UPD)
      else $error("accepted item did not enter the update step");

   // A negative target is always exactly minus one.
   a_target_neg: assert property (@(posedge clock) disable iff (reset)
      target_ff[TGT_W-1] |-> (&target_ff))
      else $error("negative target other than minus one");

   // A new result appears only out of the result step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(upc_ff == ST_SHOW))
      else $error("result raised outside the result step");
`endif

endmodule

`default_nettype wire
